// File: rtl/core/cirm_pkg.sv
package cirm_pkg;

    localparam int MAX_RANGES = 1024;
    localparam int ID_BITS    = 32;
    localparam int TYPE_BITS  = 16;

    localparam int IDX_BITS   = $clog2(MAX_RANGES);
    localparam int CNT_BITS   = IDX_BITS + 1;
    localparam int SIDX_BITS  = IDX_BITS + 2;
    localparam int GUARD_MAX  = 80;
    localparam int GUARD_BITS = $clog2(GUARD_MAX);

    localparam int CMD_BITS   = 2;
    localparam int ST_BITS    = 2;
    localparam int S_DATA_W   = ((TYPE_BITS + 3 * ID_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = ((TYPE_BITS + 2 * ID_BITS + 7) / 8) * 8;

    localparam logic [CMD_BITS-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_LOOKUP = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_CLEAR  = 2'd2;

    localparam logic [ST_BITS-1:0] ST_OK         = 2'd0;
    localparam logic [ST_BITS-1:0] ST_UNKNOWN    = 2'd1;
    localparam logic [ST_BITS-1:0] ST_NOT_CONTIG = 2'd2;
    localparam logic [ST_BITS-1:0] ST_FULL       = 2'd3;

    typedef logic [ID_BITS-1:0]   t_id;
    typedef logic [TYPE_BITS-1:0] t_type;

    typedef struct packed {
        t_id   last;
        t_id   first;
        t_type typ;
    } t_entry;

    typedef struct packed {
        t_id   query_id;
        t_id   span_last;
        t_id   span_first;
        t_type type_tag;
    } t_req;

endpackage

// File: rtl/core/contiguous_id_range_map.sv
// Contiguous ID range map.
// Slave stream takes one request per handshake: tuser is the command
// (append, lookup, clear), tdata carries type tag, range bounds and query ID.
// Master stream returns exactly one result per request: tuser is the status,
// tdata the type and bounds of the range that holds the queried ID (zero for
// anything but a successful lookup).
// Ranges live in one 1024-deep table RAM with a registered read port.
// Append, clear and rejected lookups go from S_EXEC through S_PUSH to the
// output register. A lookup bisects the table in S_SEARCH, one RAM read and
// compare per cycle, until it hits the range or misses.
// One request is in work at a time; s_axis_tready is high only when the
// engine is idle, and a new request is taken while the previous result
// still waits in the output register.
// A stalled master side holds the result and the engine parks until the
// output register frees up; nothing is dropped.
// Synchronous reset empties the table at once: no clearing pass is needed,
// as only entries below the fill count are ever read.
module contiguous_id_range_map (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // type_tag[15:0], span_first[47:16], span_last[79:48], query_id[111:80]
    input  logic [cirm_pkg::S_DATA_W-1:0] s_axis_tdata,
    // command[1:0]
    input  logic [cirm_pkg::CMD_BITS-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // found_type[15:0], found_first[47:16], found_last[79:48]
    output logic [cirm_pkg::M_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [cirm_pkg::ST_BITS-1:0]  m_axis_tuser
);
    import cirm_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_PUSH
    } t_state;

    localparam logic signed [SIDX_BITS-1:0] IDX_NONE = '1;
    localparam logic signed [SIDX_BITS-1:0] IDX_ONE  = 1;

    t_state                r_state;
    t_req                  r_req;
    logic [CMD_BITS-1:0]   r_cmd;
    logic [CNT_BITS-1:0]   r_count;
    t_id                   r_span_low;
    t_id                   r_span_high;
    t_type                 r_last_type;
    t_id                   r_last_first;
    logic [ST_BITS-1:0]    r_res_status;
    t_entry                r_res;
    logic                  r_out_valid;
    logic [ST_BITS-1:0]    r_out_status;
    t_entry                r_out;

    logic signed [SIDX_BITS-1:0] r_idx;
    logic signed [SIDX_BITS-1:0] r_left;
    logic signed [SIDX_BITS-1:0] r_right;
    logic [GUARD_BITS-1:0]       r_guard;

    t_entry                mem [MAX_RANGES];
    t_entry                r_rd;
    logic [IDX_BITS-1:0]   rd_addr;
    logic                  wr_en;
    logic [IDX_BITS-1:0]   wr_addr;
    t_entry                wr_data;

    logic signed [SIDX_BITS-1:0] n_idx;
    logic signed [SIDX_BITS-1:0] n_left;
    logic signed [SIDX_BITS-1:0] n_right;
    logic signed [SIDX_BITS-1:0] diff;
    logic signed [SIDX_BITS-1:0] half;
    logic signed [SIDX_BITS-1:0] count_s;
    logic                        hit;
    logic                        go_up;
    logic                        miss;
    logic                        out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tdata  = M_DATA_W'(r_out);
    assign out_free      = !r_out_valid || m_axis_tready;
    assign count_s       = $signed({1'b0, r_count});

    // bisection step on the entry read last cycle
    always_comb begin
        hit   = (r_req.query_id >= r_rd.first) && (r_req.query_id <= r_rd.last);
        go_up = (r_req.query_id > r_rd.last);
        diff  = go_up ? (r_right - r_idx) : (r_idx - r_left);
        half  = diff[SIDX_BITS-1] ? -((-diff) >>> 1) : (diff >>> 1);
        if (go_up) begin
            n_left  = r_idx;
            n_right = r_right;
            n_idx   = r_idx + half;
        end else begin
            n_left  = r_left;
            n_right = r_idx;
            n_idx   = r_idx - half;
        end
        miss = !((n_left + IDX_ONE) < n_right) || n_idx[SIDX_BITS-1] || (n_idx >= count_s)
               || (r_guard == GUARD_BITS'(GUARD_MAX - 1));
    end

    always_comb begin
        rd_addr = (r_state == S_EXEC) ? r_count[CNT_BITS-1:1] : n_idx[IDX_BITS-1:0];
    end

    // append write port
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[IDX_BITS-1:0];
        wr_data = '{last: r_req.span_last, first: r_req.span_first, typ: r_req.type_tag};
        if (r_state == S_EXEC && r_cmd == CMD_APPEND && r_req.span_last >= r_req.span_first)
        begin
            if (r_count == '0) begin
                wr_en   = 1'b1;
                wr_addr = '0;
            end else if (r_span_high != '1 && r_req.span_first == r_span_high + 1'b1) begin
                if (r_req.type_tag == r_last_type) begin
                    wr_en         = 1'b1;
                    wr_addr       = IDX_BITS'(r_count - 1'b1);
                    wr_data.first = r_last_first;
                end else if (r_count < CNT_BITS'(MAX_RANGES)) begin
                    wr_en = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_span_low  <= '0;
            r_span_high <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && m_axis_tready && r_state != S_PUSH) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_req   <= t_req'(s_axis_tdata[$bits(t_req)-1:0]);
                        r_cmd   <= s_axis_tuser;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    r_res <= '0;
                    case (r_cmd)
                        CMD_APPEND: begin
                            r_state <= S_PUSH;
                            if (r_req.span_last < r_req.span_first) begin
                                r_res_status <= ST_NOT_CONTIG;
                            end else if (r_count == '0) begin
                                r_res_status <= ST_OK;
                                r_count      <= CNT_BITS'(1);
                                r_span_low   <= r_req.span_first;
                                r_span_high  <= r_req.span_last;
                                r_last_type  <= r_req.type_tag;
                                r_last_first <= r_req.span_first;
                            end else if (r_span_high == '1
                                         || r_req.span_first != r_span_high + 1'b1) begin
                                r_res_status <= ST_NOT_CONTIG;
                            end else if (r_req.type_tag == r_last_type) begin
                                r_res_status <= ST_OK;
                                r_span_high  <= r_req.span_last;
                            end else if (r_count >= CNT_BITS'(MAX_RANGES)) begin
                                r_res_status <= ST_FULL;
                            end else begin
                                r_res_status <= ST_OK;
                                r_count      <= r_count + 1'b1;
                                r_span_high  <= r_req.span_last;
                                r_last_type  <= r_req.type_tag;
                                r_last_first <= r_req.span_first;
                            end
                        end
                        CMD_LOOKUP: begin
                            if (r_count == '0 || r_req.query_id == '0
                                || r_req.query_id > r_span_high
                                || r_req.query_id < r_span_low) begin
                                r_res_status <= ST_UNKNOWN;
                                r_state      <= S_PUSH;
                            end else begin
                                r_res_status <= ST_OK;
                                r_idx        <= $signed({2'b00, r_count[CNT_BITS-1:1]});
                                r_left       <= IDX_NONE;
                                r_right      <= count_s;
                                r_guard      <= '0;
                                r_state      <= S_SEARCH;
                            end
                        end
                        CMD_CLEAR: begin
                            r_res_status <= ST_OK;
                            r_state      <= S_PUSH;
                            r_count      <= '0;
                            r_span_low   <= '0;
                            r_span_high  <= '0;
                        end
                        default: begin
                            r_res_status <= ST_OK;
                            r_state      <= S_PUSH;
                        end
                    endcase
                end
                S_SEARCH: begin
                    if (hit) begin
                        r_res   <= r_rd;
                        r_state <= S_PUSH;
                    end else if (miss) begin
                        r_res_status <= ST_UNKNOWN;
                        r_state      <= S_PUSH;
                    end else begin
                        r_idx   <= n_idx;
                        r_left  <= n_left;
                        r_right <= n_right;
                        r_guard <= r_guard + 1'b1;
                    end
                end
                S_PUSH: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out        <= r_res;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
